>>> hw/rtl/ggc_pkg.sv
// Shared types and constants for the greedy graph coloring core.
// Depends on nothing; used by the core, the checker and the testbench.
`default_nettype none

package ggc_pkg;

    // Field widths of the stream payloads
    localparam int NODE_W  = 10;
    localparam int COLOR_W = 6;
    localparam int COUNT_W = 7;
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 1;

    // Request kinds carried in tuser[0]
    localparam logic OP_NEIGHBOR = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    // Reset value of the max_degree register
    localparam logic [COLOR_W-1:0] MAX_DEGREE_RST = 6'd63;

    // One stored color: valid flag plus color
    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] color;
    } t_entry;

endpackage

`default_nettype wire

>>> hw/rtl/greedy_graph_coloring_core.sv
// Greedy graph coloring core: color store, forbidden-mask accumulation,
// lowest-free-color search. Depends on ggc_pkg.
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata, tuser, tlast
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata, tuser
// cfg       in         i_cfg_valid/o_cfg_ready         i_cfg_data (max_degree)
//
// One neighbor entry per cycle, back to back, while no sweep, clear or stalled
// result holds tready low; a run's last entry passes the entry stage, and its
// result then lands in the output register. The per-entry loop is color store
// read, last-write forwarding, mask OR and the priority encoder. After reset all
// NODE_COUNT store entries are swept to uncolored with s_axis tready low; a
// clear request holds tready low until its sweep ends. While a result waits in
// the output register, entries that end no run flow on; the next result stalls.

module greedy_graph_coloring_core #(
    parameter int NODE_COUNT  = 1024,
    parameter int COLOR_COUNT = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request stream
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: node [9:0], neighbor [19:10], zero [23:20]
    input  wire  [ggc_pkg::S_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: opcode [0], neighbor_present [1]
    input  wire  [ggc_pkg::S_USER_W-1:0]      i_s_axis_tuser,
    input  wire                               i_s_axis_tlast,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // tdata: colored_node [9:0], color [15:10], color_count [22:16], zero [23]
    output logic [ggc_pkg::M_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: no_free_color [0]
    output logic [ggc_pkg::M_USER_W-1:0]      o_m_axis_tuser,
    // configuration: max_degree
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [ggc_pkg::COLOR_W-1:0]       i_cfg_data
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // Color store
    ggc_pkg::t_entry r_mem [NODE_COUNT];
    ggc_pkg::t_entry r_rd_data;

    // Configuration
    logic [ggc_pkg::COLOR_W-1:0] r_max_degree;

    // Entry stage (read data present)
    logic                        r1_valid;
    logic                        r1_op;
    logic [ggc_pkg::NODE_W-1:0]  r1_node;
    logic [AW-1:0]               r1_node_addr;
    logic                        r1_node_ok;
    logic [AW-1:0]               r1_nb_addr;
    logic                        r1_nb_ok;
    logic                        r1_present;
    logic                        r1_last;

    // Last store write, for forwarding
    logic                        r_wr_valid;
    logic [AW-1:0]               r_wr_addr;
    ggc_pkg::t_entry             r_wr_entry;

    // Coloring state
    logic [COLOR_COUNT-1:0]      r_mask;
    logic [ggc_pkg::COLOR_W-1:0] r_highest;
    logic                        r_edge_seen;

    // Clearing sweep
    logic                        r_sweep;
    logic [AW-1:0]               r_sweep_addr;

    // Output register
    logic                        r_out_valid;
    logic [ggc_pkg::NODE_W-1:0]  r_out_node;
    logic [ggc_pkg::COLOR_W-1:0] r_out_color;
    logic [ggc_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_nofree;

    // Combinational signals
    logic                        in_fire;
    logic                        s1_adv;
    logic                        s1_fire;
    logic                        s1_result;
    logic                        out_free;
    logic [ggc_pkg::NODE_W-1:0]  in_node;
    logic [ggc_pkg::NODE_W-1:0]  in_nb;
    ggc_pkg::t_entry             entry;
    logic                        hit;
    logic [COLOR_COUNT-1:0]      entry_mask;
    logic [COLOR_COUNT-1:0]      mask_full;
    logic [COLOR_COUNT-1:0]      avail;
    logic [ggc_pkg::COLOR_W-1:0] limit;
    logic                        found;
    logic [ggc_pkg::COLOR_W-1:0] chosen;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    ggc_pkg::t_entry             mem_wdata;
    logic                        s1_wr;
    logic [COLOR_COUNT-1:0]      n_mask;
    logic [ggc_pkg::COLOR_W-1:0] n_highest;
    logic                        n_edge_seen;
    logic [ggc_pkg::COUNT_W-1:0] n_count;

    assign in_node = i_s_axis_tdata[ggc_pkg::NODE_W-1:0];
    assign in_nb   = i_s_axis_tdata[2*ggc_pkg::NODE_W-1:ggc_pkg::NODE_W];

    // Handshakes
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign s1_result = (r1_op == ggc_pkg::OP_NEIGHBOR) && r1_last;
    assign s1_adv    = !s1_result || out_free;
    assign s1_fire   = r1_valid && s1_adv;
    assign o_s_axis_tready = !r_sweep && !(r1_valid && r1_op == ggc_pkg::OP_CLEAR)
                             && (!r1_valid || s1_adv);
    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Forward the last write over the stale read
    always_comb begin
        if (r_wr_valid && r_wr_addr == r1_nb_addr) begin
            entry = r_wr_entry;
        end else begin
            entry = r_rd_data;
        end
        hit = (r1_op == ggc_pkg::OP_NEIGHBOR) && r1_present && r1_nb_ok && entry.valid;
    end

    // Mark the neighbor's color forbidden
    always_comb begin
        for (int c = 0; c < COLOR_COUNT; c++) begin
            entry_mask[c] = hit && (entry.color == ggc_pkg::COLOR_W'(c));
        end
        mask_full = r_mask | entry_mask;
    end

    // Search the lowest free color up to the clamped max_degree
    always_comb begin
        if (32'(r_max_degree) > COLOR_COUNT - 1) begin
            limit = ggc_pkg::COLOR_W'(COLOR_COUNT - 1);
        end else begin
            limit = r_max_degree;
        end
        for (int c = 0; c < COLOR_COUNT; c++) begin
            avail[c] = !mask_full[c] && (ggc_pkg::COLOR_W'(c) <= limit);
        end
        found  = 1'b0;
        chosen = '0;
        for (int c = COLOR_COUNT - 1; c >= 0; c--) begin
            if (avail[c]) begin
                found  = 1'b1;
                chosen = ggc_pkg::COLOR_W'(c);
            end
        end
    end

    // Next coloring state; the highest color moves only at the end of a run
    always_comb begin
        s1_wr       = s1_fire && s1_result && found && r1_node_ok;
        n_edge_seen = r_edge_seen
                      || (r1_op == ggc_pkg::OP_NEIGHBOR && r1_present);
        if (r1_last && found && chosen > r_highest) begin
            n_highest = chosen;
        end else begin
            n_highest = r_highest;
        end
        if (r1_last) begin
            n_mask = '0;
        end else begin
            n_mask = mask_full;
        end
        if (n_edge_seen) begin
            n_count = ggc_pkg::COUNT_W'(n_highest) + ggc_pkg::COUNT_W'(1);
        end else begin
            n_count = '0;
        end
    end

    // Store write port: sweep or a newly colored node
    always_comb begin
        if (r_sweep) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep_addr;
            mem_wdata = '0;
        end else begin
            mem_we          = s1_wr;
            mem_waddr       = r1_node_addr;
            mem_wdata.valid = 1'b1;
            mem_wdata.color = chosen;
        end
    end

    // Color store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire) begin
            r_rd_data <= r_mem[AW'(in_nb)];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_degree <= ggc_pkg::MAX_DEGREE_RST;
            r1_valid     <= 1'b0;
            r_wr_valid   <= 1'b0;
            r_mask       <= '0;
            r_highest    <= '0;
            r_edge_seen  <= 1'b0;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_degree <= i_cfg_data;
            end

            // Advance the entry stage
            if (in_fire) begin
                r1_valid <= 1'b1;
            end else if (s1_fire) begin
                r1_valid <= 1'b0;
            end

            // Step the sweep
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                if (r_sweep_addr == AW'(NODE_COUNT - 1)) begin
                    r_sweep <= 1'b0;
                end
            end

            // Update coloring state
            if (s1_fire) begin
                if (r1_op == ggc_pkg::OP_CLEAR) begin
                    r_mask       <= '0;
                    r_highest    <= '0;
                    r_edge_seen  <= 1'b0;
                    r_wr_valid   <= 1'b0;
                    r_sweep      <= 1'b1;
                    r_sweep_addr <= '0;
                end else begin
                    r_mask      <= n_mask;
                    r_highest   <= n_highest;
                    r_edge_seen <= n_edge_seen;
                    if (s1_wr) begin
                        r_wr_valid <= 1'b1;
                    end
                end
            end

            // Hold or drop the output register
            if (s1_fire && s1_result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r1_op        <= i_s_axis_tuser[0];
            r1_present   <= i_s_axis_tuser[1];
            r1_last      <= i_s_axis_tlast;
            r1_node      <= in_node;
            r1_node_addr <= AW'(in_node);
            r1_node_ok   <= 32'(in_node) < NODE_COUNT;
            r1_nb_addr   <= AW'(in_nb);
            r1_nb_ok     <= 32'(in_nb) < NODE_COUNT;
        end
        if (s1_wr) begin
            r_wr_addr        <= r1_node_addr;
            r_wr_entry.valid <= 1'b1;
            r_wr_entry.color <= chosen;
        end
        if (s1_fire && s1_result) begin
            r_out_node   <= r1_node;
            r_out_color  <= found ? chosen : '0;
            r_out_count  <= n_count;
            r_out_nofree <= !found;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_color, r_out_node};
    assign o_m_axis_tuser  = r_out_nofree;

`ifndef SYNTHESIS
    // No request is taken while the store is being cleared
    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !o_s_axis_tready)
        else $error("request accepted during clearing sweep");

    // Sweep and node write never share the write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sweep && s1_wr))
        else $error("sweep and node write collide");

    // A failed search reports color zero
    a_nofree_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nofree) |-> (r_out_color == '0))
        else $error("no_free_color with nonzero color");

    // A reported color lies below a nonzero color count
    a_color_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_nofree && r_out_count != '0)
        |-> (ggc_pkg::COUNT_W'(r_out_color) < r_out_count))
        else $error("color not below color count");
`endif

endmodule

`default_nettype wire

>>> bench/greedy_graph_coloring_checker.sv
// Checker for the greedy graph coloring core: watches the request, result and
// configuration channels, predicts every coloring and compares. Depends on ggc_pkg.
`timescale 1ns / 100ps

module greedy_graph_coloring_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    input  wire                          i_s_tready,
    // tdata: node [9:0], neighbor [19:10], zero [23:20]
    input  wire  [ggc_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: opcode [0], neighbor_present [1]
    input  wire  [ggc_pkg::S_USER_W-1:0] i_s_tuser,
    input  wire                          i_s_tlast,
    input  wire                          i_m_tvalid,
    input  wire                          i_m_tready,
    // tdata: colored_node [9:0], color [15:10], color_count [22:16], zero [23]
    input  wire  [ggc_pkg::M_DATA_W-1:0] i_m_tdata,
    // tuser: no_free_color [0]
    input  wire  [ggc_pkg::M_USER_W-1:0] i_m_tuser,
    input  wire                          i_cfg_valid,
    input  wire                          i_cfg_ready,
    input  wire  [ggc_pkg::COLOR_W-1:0]  i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int NODES = 1024;

    typedef struct packed {
        logic [ggc_pkg::NODE_W-1:0]  node;
        logic [ggc_pkg::COLOR_W-1:0] color;
        logic [ggc_pkg::COUNT_W-1:0] count;
        logic                        no_free;
    } t_coloring;

    // Shadow copy of the coloring state
    ggc_pkg::t_entry             shadow_colors [NODES];
    logic [63:0]                 forbidden;
    logic [ggc_pkg::COLOR_W-1:0] highest_color;
    logic                        edge_seen;
    logic [ggc_pkg::COLOR_W-1:0] max_degree;
    t_coloring                   awaited_colors [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Forget every stored color and start a new coloring
    task automatic clear_coloring();
        int i;
        for (i = 0; i < NODES; i++) begin
            shadow_colors[i] = '0;
        end
        forbidden     = '0;
        highest_color = '0;
        edge_seen     = 1'b0;
    endtask

    // Apply one accepted request; queue the coloring it completes
    task automatic take_request(input logic op, input logic [ggc_pkg::NODE_W-1:0] node,
                                input logic [ggc_pkg::NODE_W-1:0] nb,
                                input logic present, input logic last);
        t_coloring                   res;
        int                          c;
        logic                        found;
        logic [ggc_pkg::COLOR_W-1:0] chosen;
        if (op == ggc_pkg::OP_CLEAR) begin
            clear_coloring();
        end else begin
            if (present) begin
                edge_seen = 1'b1;
                if (shadow_colors[nb].valid) begin
                    forbidden = forbidden | (64'd1 << shadow_colors[nb].color);
                end
            end
            if (last) begin
                found  = 1'b0;
                chosen = '0;
                for (c = 0; c <= max_degree; c++) begin
                    if (!found && !forbidden[c]) begin
                        found  = 1'b1;
                        chosen = c[ggc_pkg::COLOR_W-1:0];
                    end
                end
                if (found) begin
                    shadow_colors[node].valid = 1'b1;
                    shadow_colors[node].color = chosen;
                    if (chosen > highest_color) begin
                        highest_color = chosen;
                    end
                end
                forbidden   = '0;
                res.node    = node;
                res.color   = chosen;
                res.count   = edge_seen ? {1'b0, highest_color} + 7'd1 : 7'd0;
                res.no_free = !found;
                awaited_colors.insert(awaited_colors.size(), res);
            end
        end
    endtask

    // Report one field that differs
    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Match one delivered result against the oldest awaited coloring
    task automatic check_result();
        t_coloring want;
        if (awaited_colors.size() == 0) begin
            $error("unexpected result: node %0d color %0d",
                   i_m_tdata[9:0], i_m_tdata[15:10]);
            o_fail_count++;
        end else begin
            want = awaited_colors.pop_front();
            compare_field("colored_node", want.node, i_m_tdata[9:0]);
            compare_field("color", want.color, i_m_tdata[15:10]);
            compare_field("color_count", want.count, i_m_tdata[22:16]);
            compare_field("no_free_color", want.no_free, i_m_tuser[0]);
        end
    endtask

    // Sample all channels at the rising edge; results first, they are older
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_coloring();
            max_degree = ggc_pkg::MAX_DEGREE_RST;
            awaited_colors.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                max_degree = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                take_request(i_s_tuser[0], i_s_tdata[9:0], i_s_tdata[19:10],
                             i_s_tuser[1], i_s_tlast);
            end
        end
        o_pending = awaited_colors.size();
    end

endmodule

>>> bench/greedy_graph_coloring_core_test.sv
// Testbench top for the greedy graph coloring core: clock, reset, request
// stimulus, result back pressure and verdict. Depends on ggc_pkg and the checker.
`timescale 1ns / 100ps

module greedy_graph_coloring_core_test;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 290;
    localparam int POOL_DEPTH       = 24;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         s_tvalid    = 1'b0;
    logic [ggc_pkg::S_DATA_W-1:0] s_tdata     = '0;
    logic [ggc_pkg::S_USER_W-1:0] s_tuser     = '0;
    logic                         s_tlast     = 1'b0;
    logic                         m_tready    = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic [ggc_pkg::COLOR_W-1:0]  cfg_data    = '0;
    wire                          s_tready;
    wire                          m_tvalid;
    wire  [ggc_pkg::M_DATA_W-1:0] m_tdata;
    wire  [ggc_pkg::M_USER_W-1:0] m_tuser;
    wire                          cfg_ready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int phase;
    int degree;

    logic [ggc_pkg::NODE_W-1:0] colored_pool [$];

    greedy_graph_coloring_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    greedy_graph_coloring_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result back pressure: long hold-off on request, random stalls otherwise
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_requests != hold_taken) begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request with random idle gaps; call and return at a falling edge
    task automatic send_request(input logic op, input logic [ggc_pkg::NODE_W-1:0] node,
                                input logic [ggc_pkg::NODE_W-1:0] nb,
                                input logic present, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, nb, node};
        s_tuser  <= {present, op};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
        if (op == ggc_pkg::OP_NEIGHBOR && last) begin
            colored_pool.insert(colored_pool.size(), node);
            if (colored_pool.size() > POOL_DEPTH) begin
                colored_pool.delete(0);
            end
        end
    endtask

    // Send one node's neighbor run, mostly naming recently colored nodes
    task automatic send_run(input logic [ggc_pkg::NODE_W-1:0] node, input int entries);
        int                         k;
        logic [ggc_pkg::NODE_W-1:0] nb;
        logic                       last;
        for (k = 0; k < entries; k++) begin
            if (colored_pool.size() > 0 && $urandom_range(99) < 80) begin
                nb = colored_pool[$urandom_range(colored_pool.size() - 1)];
            end else begin
                nb = ggc_pkg::NODE_W'($urandom_range(1023));
            end
            last = (k == entries - 1);
            send_request(ggc_pkg::OP_NEIGHBOR,
                         last ? node : ggc_pkg::NODE_W'($urandom_range(1023)), nb,
                         $urandom_range(9) != 0, last);
        end
    endtask

    // Color a clique of distinct nodes; each run names all earlier members
    task automatic color_clique(input int size);
        logic [ggc_pkg::NODE_W-1:0] members [$];
        int                         order [$];
        logic [ggc_pkg::NODE_W-1:0] cand;
        logic                       dup;
        int                         k, i, j, tmp;
        while (members.size() < size) begin
            cand = ggc_pkg::NODE_W'($urandom_range(1023));
            dup  = 1'b0;
            foreach (members[m]) begin
                if (members[m] == cand) begin
                    dup = 1'b1;
                end
            end
            if (!dup) begin
                members.insert(members.size(), cand);
            end
        end
        send_request(ggc_pkg::OP_NEIGHBOR, members[0],
                     ggc_pkg::NODE_W'($urandom_range(1023)), 1'b0, 1'b1);
        for (k = 1; k < size; k++) begin
            order.delete();
            for (i = 0; i < k; i++) begin
                order.insert(order.size(), i);
            end
            for (i = k - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < k; i++) begin
                send_request(ggc_pkg::OP_NEIGHBOR, members[k], members[order[i]], 1'b1,
                             i == k - 1);
            end
        end
    endtask

    // Drain all results, let the pipeline settle, then write max_degree
    task automatic write_max_degree(input logic [ggc_pkg::COLOR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed runs and cliques, some clears and loose requests
    task automatic random_requests(input int count);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if (colored_pool.size() > 0 && $urandom_range(3) == 0) begin
                    send_run(colored_pool[$urandom_range(colored_pool.size() - 1)],
                             $urandom_range(1, 6));
                end else begin
                    send_run(ggc_pkg::NODE_W'($urandom_range(1023)),
                             $urandom_range(1, 6));
                end
            end else if (pick < 80) begin
                color_clique($urandom_range(2, 6));
            end else if (pick < 82) begin
                send_request(ggc_pkg::OP_CLEAR, ggc_pkg::NODE_W'($urandom_range(1023)),
                             ggc_pkg::NODE_W'($urandom_range(1023)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                send_request(($urandom_range(7) == 0) ? ggc_pkg::OP_CLEAR
                                                      : ggc_pkg::OP_NEIGHBOR,
                             ggc_pkg::NODE_W'($urandom_range(1023)),
                             ggc_pkg::NODE_W'($urandom_range(1023)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
        // close any run a loose request left open
        send_run(ggc_pkg::NODE_W'($urandom_range(1023)), 1);
    endtask

    initial begin
        // hold reset, then release it at a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // isolated node before any edge, then a first edge
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd0, 10'd1023, 1'b0, 1'b1);
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd1023, 10'd0, 1'b1, 1'b1);
        // colored, uncolored and edgeless entries in one run
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd512, 10'd1023, 1'b1, 1'b0);
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd512, 10'd0, 1'b1, 1'b0);
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd512, 10'd700, 1'b1, 1'b0);
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd512, 10'd5, 1'b0, 1'b1);
        // clear with every other field high, then color again
        send_request(ggc_pkg::OP_CLEAR, 10'd1023, 10'd1023, 1'b1, 1'b1);
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd1023, 10'd512, 1'b1, 1'b1);
        // single color only: neighbor already holds it, no free color
        write_max_degree(6'd0);
        send_request(ggc_pkg::OP_NEIGHBOR, 10'd7, 10'd1023, 1'b1, 1'b1);
        // clique one larger than the colors available
        write_max_degree(6'd3);
        color_clique(5);

        // three phases of random requests with changing idle patterns
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 71;
                    degree        = 2;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 35;
                    degree        = 63;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    degree        = $urandom_range(63);
                end
            endcase
            write_max_degree(degree[ggc_pkg::COLOR_W-1:0]);
            if (phase != 1) begin
                hold_requests++;
            end else begin
                // a wider clique under the full color range
                color_clique(8);
            end
            random_requests(RANDOM_PER_PHASE);
        end

        // wait for the last results, then report the verdict
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
